[sv/ppi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline profile interpolator package
// Operation codes, fixed-point constants and the sequencer state type.
// ----------------------------------------------------------------------------
package ppi_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_DIF,
        ST_ADD_SQX,
        ST_ADD_SQY,
        ST_ADD_SUM,
        ST_ADD_SQRT,
        ST_ADD_WR,
        ST_Q_MULS,
        ST_Q_IDX,
        ST_Q_RDB,
        ST_Q_LD,
        ST_Q_MUL,
        ST_Q_ADD,
        ST_DONE
    } state_t;

    localparam int FRAC_BITS = 17;
    localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;
    localparam logic signed [15:0] NEG_PI_Q13  = -16'sd25736;
    localparam logic [31:0] MAX_LEN = 32'h7FFF_FFFF;
    localparam logic signed [17:0] POS_MIN = -18'sd65536;
    localparam logic signed [17:0] POS_MAX = 18'sd65536;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] roll;
        logic [31:0]        arc;
    } entry_t;

endpackage

[sv/polyline_profile_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline profile interpolator
// Point table with arc length, append with segment length, and interpolation.
// ----------------------------------------------------------------------------
// One request is processed at a time. A clear, an unused code, a refused add or
// a query on an empty table goes straight to the done state; the add of the
// first point goes through the write state only; any other accepted add reads
// the last point and runs the 32-step bit-serial square root of the segment
// length; any other query makes two reads of the single-port point memory and
// four interpolations that share one multiplier. A result that is not taken holds
// the block in its done state. A new request can be accepted while the previous
// result still waits in the output register.
module polyline_profile_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [15:0] roll_in,
    input  logic signed [17:0] position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_lateral,
    output logic signed [15:0] out_roll,
    output logic [6:0]         point_count,
    output logic               full_flag
);
    import ppi_pkg::*;

    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SW   = 18 + CNTW;
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_POINTS);

    entry_t mem [MAX_POINTS];
    entry_t rd_data_reg;
    logic [IDXW-1:0] rd_addr;
    logic            rd_en;
    logic            wr_en;

    state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [31:0]     total_reg, total_next;
    logic            out_valid_reg, out_valid_next;

    logic [1:0]         op_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] pr_reg;
    logic signed [17:0] pos_reg;

    logic [32:0]  ax_reg, ay_reg;
    logic         sat_reg;
    logic [61:0]  sqx_reg, sqy_reg;
    logic [63:0]  rad_reg;
    logic [33:0]  rem_reg;
    logic [31:0]  root_reg;
    logic [4:0]   step_reg;

    logic [SW-1:0]   s_reg;
    logic [CNTW:0]   idx_reg;
    logic [17:0]     frac_reg;
    entry_t          a_reg, b_reg;
    logic [1:0]      fld_reg;
    logic signed [52:0] prod_reg;

    logic signed [31:0] res_x_reg, res_y_reg, res_lat_reg;
    logic signed [15:0] res_roll_reg;
    logic               res_full_reg;

    logic signed [31:0] ox_reg, oy_reg, olat_reg;
    logic signed [15:0] oroll_reg;
    logic [6:0]         ocnt_reg;
    logic               ofull_reg;

    logic in_fire, out_free;
    logic signed [17:0] pos_c;
    logic [17:0]        u;
    logic [CNTW-1:0]    nsegs;
    logic [CNTW:0]      idx_raw;
    logic               idx_over;
    logic [CNTW:0]      idx_sel;
    logic [17:0]        frac_sel;
    logic signed [33:0] dx, dy;
    logic [35:0]        r2, trial;
    logic [31:0]        seg;
    logic [32:0]        tsum;
    logic signed [32:0] fa, fb;
    logic signed [33:0] diff;
    logic signed [53:0] tval;
    logic signed [34:0] lerp_r;
    logic signed [34:0] lat;
    logic [CNTW+6:0]    cnt_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_lateral = olat_reg;
    assign out_roll    = oroll_reg;
    assign point_count = ocnt_reg;
    assign full_flag   = ofull_reg;

    always_comb
    begin
        if (pos_reg < POS_MIN)
        begin
            pos_c = POS_MIN;
        end
        else if (pos_reg > POS_MAX)
        begin
            pos_c = POS_MAX;
        end
        else
        begin
            pos_c = pos_reg;
        end
    end

    assign u        = 18'(19'(pos_c) + 19'sd65536);
    assign nsegs    = count_reg - CNTW'(1);
    assign idx_raw  = (CNTW + 1)'(s_reg >> FRAC_BITS);
    assign idx_over = (idx_raw >= {1'b0, nsegs});
    assign idx_sel  = idx_over ? {1'b0, nsegs} - (CNTW + 1)'(1) : idx_raw;
    assign frac_sel = idx_over ? 18'd131072 : {1'b0, s_reg[FRAC_BITS-1:0]};

    assign dx = 34'(px_reg) - 34'(rd_data_reg.x);
    assign dy = 34'(py_reg) - 34'(rd_data_reg.y);

    assign r2    = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};

    assign seg  = (sat_reg || root_reg > MAX_LEN) ? MAX_LEN : root_reg;
    assign tsum = {1'b0, total_reg} + {1'b0, seg};

    always_comb
    begin
        case (fld_reg)
            2'd0:
            begin
                fa = 33'(a_reg.x);
                fb = 33'(b_reg.x);
            end
            2'd1:
            begin
                fa = 33'(a_reg.y);
                fb = 33'(b_reg.y);
            end
            2'd2:
            begin
                fa = 33'(a_reg.roll);
                fb = 33'(b_reg.roll);
            end
            default:
            begin
                fa = $signed({1'b0, a_reg.arc});
                fb = $signed({1'b0, b_reg.arc});
            end
        endcase
    end

    assign diff   = 34'(fb) - 34'(fa);
    assign tval   = 54'(prod_reg) + 54'sd65536;
    assign lerp_r = 35'(fa) + 35'(tval >>> FRAC_BITS);
    assign lat    = lerp_r - $signed({3'b000, total_reg[31:1]});
    assign cnt_ext = {7'd0, count_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            state_next = ST_DONE;
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_ADD_WR;
                            end
                            else
                            begin
                                state_next = ST_ADD_RD;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_Q_MULS;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = nsegs[IDXW-1:0];
                state_next = ST_ADD_DIF;
            end
            ST_ADD_DIF:  state_next = ST_ADD_SQX;
            ST_ADD_SQX:  state_next = ST_ADD_SQY;
            ST_ADD_SQY:  state_next = ST_ADD_SUM;
            ST_ADD_SUM:  state_next = ST_ADD_SQRT;
            ST_ADD_SQRT:
            begin
                if (step_reg == 5'd31)
                begin
                    state_next = ST_ADD_WR;
                end
            end
            ST_ADD_WR:
            begin
                wr_en      = 1'b1;
                total_next = tsum[32] ? MAX_LEN : (tsum[31:0] > MAX_LEN ? MAX_LEN : tsum[31:0]);
                count_next = count_reg + CNTW'(1);
                state_next = ST_DONE;
            end
            ST_Q_MULS:   state_next = ST_Q_IDX;
            ST_Q_IDX:
            begin
                rd_en      = 1'b1;
                rd_addr    = (count_reg == CNTW'(1)) ? '0 : idx_sel[IDXW-1:0];
                state_next = ST_Q_RDB;
            end
            ST_Q_RDB:
            begin
                rd_en      = 1'b1;
                rd_addr    = (count_reg == CNTW'(1)) ? '0 : IDXW'(idx_reg + (CNTW + 1)'(1));
                state_next = ST_Q_LD;
            end
            ST_Q_LD:     state_next = ST_Q_MUL;
            ST_Q_MUL:    state_next = ST_Q_ADD;
            ST_Q_ADD:
            begin
                state_next = (fld_reg == 2'd3) ? ST_DONE : ST_Q_MUL;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDXW-1:0]] <= '{x: px_reg, y: py_reg, roll: pr_reg,
                                         arc: total_next};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg       <= operation;
                    px_reg       <= point_x;
                    py_reg       <= point_y;
                    pr_reg       <= roll_in;
                    pos_reg      <= position;
                    sat_reg      <= 1'b0;
                    root_reg     <= '0;
                    res_x_reg    <= '0;
                    res_y_reg    <= '0;
                    res_lat_reg  <= '0;
                    res_roll_reg <= '0;
                    res_full_reg <= (operation == OP_ADD) && (count_reg >= MAX_CNT);
                end
            end
            ST_ADD_DIF:
            begin
                ax_reg  <= dx[33] ? 33'(-dx) : 33'(dx);
                ay_reg  <= dy[33] ? 33'(-dy) : 33'(dy);
            end
            ST_ADD_SQX:
            begin
                sat_reg <= (ax_reg >= {1'b0, MAX_LEN}) || (ay_reg >= {1'b0, MAX_LEN});
                sqx_reg <= ax_reg[30:0] * ax_reg[30:0];
            end
            ST_ADD_SQY:
            begin
                sqy_reg <= ay_reg[30:0] * ay_reg[30:0];
            end
            ST_ADD_SUM:
            begin
                rad_reg  <= {2'b00, sqx_reg} + {2'b00, sqy_reg};
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
            end
            ST_ADD_SQRT:
            begin
                rad_reg  <= {rad_reg[61:0], 2'b00};
                step_reg <= step_reg + 5'd1;
                if (r2 >= trial)
                begin
                    rem_reg  <= 34'(r2 - trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= r2[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            ST_Q_MULS:
            begin
                s_reg <= SW'(u * nsegs);
            end
            ST_Q_IDX:
            begin
                idx_reg  <= (count_reg == CNTW'(1)) ? '0 : idx_sel;
                frac_reg <= (count_reg == CNTW'(1)) ? '0 : frac_sel;
                fld_reg  <= 2'd0;
            end
            ST_Q_RDB:
            begin
                a_reg <= rd_data_reg;
            end
            ST_Q_LD:
            begin
                b_reg <= rd_data_reg;
            end
            ST_Q_MUL:
            begin
                prod_reg <= 53'(diff * $signed({1'b0, frac_reg}));
            end
            ST_Q_ADD:
            begin
                fld_reg <= fld_reg + 2'd1;
                case (fld_reg)
                    2'd0: res_x_reg    <= lerp_r[31:0];
                    2'd1: res_y_reg    <= lerp_r[31:0];
                    2'd2: res_roll_reg <= lerp_r[15:0];
                    default:
                    begin
                        if (lat > 35'sd2147483647)
                        begin
                            res_lat_reg <= 32'sh7FFF_FFFF;
                        end
                        else if (lat < -35'sd2147483648)
                        begin
                            res_lat_reg <= 32'sh8000_0000;
                        end
                        else
                        begin
                            res_lat_reg <= lat[31:0];
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (op_reg == OP_QUERY && count_reg == '0)
                    begin
                        ox_reg    <= NEG_ONE_Q16;
                        oy_reg    <= NEG_ONE_Q16;
                        olat_reg  <= 32'(pos_c);
                        oroll_reg <= NEG_PI_Q13;
                    end
                    else
                    begin
                        ox_reg    <= res_x_reg;
                        oy_reg    <= res_y_reg;
                        olat_reg  <= res_lat_reg;
                        oroll_reg <= res_roll_reg;
                    end
                    ocnt_reg  <= cnt_ext[6:0];
                    ofull_reg <= res_full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[sv/ppi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline profile interpolator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ppi_checker #(
    parameter int MAX_POINTS = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_lateral,
    input logic signed [15:0] out_roll,
    input logic [6:0]         point_count,
    input logic               full_flag
);
    import ppi_pkg::*;

    localparam logic [6:0] MAX_LOW = 7'(MAX_POINTS);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_lateral)
            && $stable(point_count))
        else $error("A waiting result changed before it was taken.");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_flag |-> out_x == 0 && out_y == 0 && out_lateral == 0
            && out_roll == 0)
        else $error("A refused add carried nonzero values.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_flag |-> point_count == MAX_LOW)
        else $error("A refused add was flagged with a table that was not full.");

    a_empty_lat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (MAX_POINTS < 128) && point_count == 0 && out_roll == NEG_PI_Q13
            && out_x == NEG_ONE_Q16 |-> out_lateral >= -32'sd65536
            && out_lateral <= 32'sd65536)
        else $error("An empty-table query gave a position out of range.");

endmodule

bind polyline_profile_interpolator ppi_checker #(.MAX_POINTS(MAX_POINTS)) u_ppi_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x(out_x),
    .out_y(out_y),
    .out_lateral(out_lateral),
    .out_roll(out_roll),
    .point_count(point_count),
    .full_flag(full_flag)
);
